// ===== rtl/sis_pkg.sv =====
`default_nettype none

package sis_pkg;

    // Store size and derived widths.
    localparam int CAPACITY   = 256;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int WIDTH_W    = 4;
    localparam int LEN_W      = 12;
    localparam int VALUE_W    = 64;
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = CAPACITY / GROUP_SIZE;

    // Element widths in bytes.
    localparam logic [WIDTH_W-1:0] W_BYTES_2 = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0] W_BYTES_4 = WIDTH_W'(4);
    localparam logic [WIDTH_W-1:0] W_BYTES_8 = WIDTH_W'(8);

    typedef logic signed [VALUE_W-1:0] t_entry;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_REMOVE = 2'd1,
        K_FIND   = 2'd2,
        K_GET    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_UPD
    } t_state;

    // Input word: one operation.
    typedef struct packed {
        t_kind               kind;
        t_entry              value;
        logic [INDEX_W-1:0]  index;
    } t_in_word;

    // Output word: one result.
    typedef struct packed {
        t_status             status;
        t_entry              read_value;
        logic [COUNT_W-1:0]  count;
        logic [WIDTH_W-1:0]  width_bytes;
        logic [LEN_W-1:0]    byte_length;
    } t_out_word;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                cmp;
        logic                ins;
        logic                del;
        t_entry              value;
        logic [INDEX_W-1:0]  index;
        logic [COUNT_W-1:0]  count;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/sorted_integer_set.sv =====
// Channel | Direction | Word       | Handshake
// in      | input     | t_in_word  | i_in_valid / o_in_stall
// out     | output    | t_out_word | o_out_valid / i_out_stall
//
// Each operation passes through the accepting state, a compare in all
// 256 cells, a registered reduction over groups of 16 cells, and the
// decision state in which the cells shift and the result is registered.
// Reset empties the set and sets the width to two bytes; no clearing pass.
// A result waiting under stall holds the decision cycle; a new word may
// still be accepted while an earlier result waits in the output register.
`default_nettype none

module sorted_integer_set
    import sis_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    t_state             r_state;
    t_state             n_state;
    t_in_word           r_op;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [WIDTH_W-1:0] r_width;
    logic [WIDTH_W-1:0] n_width;
    logic               r_out_valid;
    t_out_word          r_out;
    t_out_word          n_out;

    t_cell_ctrl         cell_ctrl;
    t_entry             c_entry [CAPACITY];
    logic [CAPACITY-1:0] c_lt;
    logic [CAPACITY-1:0] c_eq;
    logic [CAPACITY-1:0] c_sel;
    logic [NUM_GROUPS-1:0] g_hit;
    t_entry             g_rd [NUM_GROUPS];

    logic               hit;
    t_entry             rd_all;
    logic               full;
    logic               out_free;
    logic               upd_go;
    logic               ins_ok;
    logic               del_ok;
    t_status            upd_status;
    t_entry             upd_rd;
    logic               fits16;
    logic               fits32;
    logic [WIDTH_W-1:0] need;

    // Row of cells, reduced in groups.
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        t_entry grp_entry [GROUP_SIZE];
        for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_cell
            localparam int P = g * GROUP_SIZE + j;
            t_entry left_entry;
            logic   left_lt;
            t_entry right_entry;
            if (P == 0) begin : g_first
                assign left_entry = c_entry[P];
                assign left_lt    = 1'b1;
            end else begin : g_mid
                assign left_entry = c_entry[P-1];
                assign left_lt    = c_lt[P-1];
            end
            if (P == CAPACITY - 1) begin : g_last
                assign right_entry = c_entry[P];
            end else begin : g_inner
                assign right_entry = c_entry[P+1];
            end
            sis_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (cell_ctrl),
                .i_pos         (INDEX_W'(P)),
                .i_left_entry  (left_entry),
                .i_left_lt     (left_lt),
                .i_right_entry (right_entry),
                .o_entry       (c_entry[P]),
                .o_lt          (c_lt[P]),
                .o_eq          (c_eq[P]),
                .o_sel         (c_sel[P])
            );
            assign grp_entry[j] = c_entry[P];
        end
        sis_group u_group (
            .i_clk   (i_clk),
            .i_eq    (c_eq[g*GROUP_SIZE +: GROUP_SIZE]),
            .i_sel   (c_sel[g*GROUP_SIZE +: GROUP_SIZE]),
            .i_entry (grp_entry),
            .o_hit   (g_hit[g]),
            .o_rd    (g_rd[g])
        );
    end

    // Final reduction over the group results.
    always_comb begin
        rd_all = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            rd_all = rd_all | g_rd[g];
        end
    end
    assign hit = |g_hit;

    // Width an added value needs.
    assign fits16 = (&r_op.value[VALUE_W-1:15]) || !(|r_op.value[VALUE_W-1:15]);
    assign fits32 = (&r_op.value[VALUE_W-1:31]) || !(|r_op.value[VALUE_W-1:31]);
    assign need   = fits16 ? W_BYTES_2 : (fits32 ? W_BYTES_4 : W_BYTES_8);

    // Operation decision.
    assign full = (r_count == COUNT_W'(CAPACITY));
    always_comb begin
        upd_status = ST_OK;
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        upd_rd     = '0;
        unique case (r_op.kind)
            K_ADD: begin
                if (full) begin
                    upd_status = ST_FULL;
                end else if (hit) begin
                    upd_status = ST_MISS;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            K_REMOVE: begin
                if (!hit) begin
                    upd_status = ST_MISS;
                end else begin
                    del_ok = 1'b1;
                end
            end
            K_FIND: begin
                if (!hit) begin
                    upd_status = ST_MISS;
                end
            end
            K_GET: begin
                if ({1'b0, r_op.index} >= r_count) begin
                    upd_status = ST_RANGE;
                end else begin
                    upd_rd = rd_all;
                end
            end
            default: upd_status = ST_OK;
        endcase
    end

    // New count, width and the result word.
    always_comb begin
        n_count = r_count;
        n_width = r_width;
        if (ins_ok) begin
            n_count = r_count + COUNT_W'(1);
            if (need > r_width) begin
                n_width = need;
            end
        end else if (del_ok) begin
            n_count = r_count - COUNT_W'(1);
        end
        n_out.status      = upd_status;
        n_out.read_value  = upd_rd;
        n_out.count       = n_count;
        n_out.width_bytes = n_width;
        unique case (n_width)
            W_BYTES_2: n_out.byte_length = LEN_W'({n_count, 1'b0});
            W_BYTES_4: n_out.byte_length = LEN_W'({n_count, 2'b0});
            W_BYTES_8: n_out.byte_length = LEN_W'({n_count, 3'b0});
            default:   n_out.byte_length = '0;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CMP;
            S_CMP:  n_state = S_RED;
            S_RED:  n_state = S_UPD;
            S_UPD:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        upd_go          = (r_state == S_UPD) && out_free;
        cell_ctrl.cmp   = (r_state == S_CMP);
        cell_ctrl.ins   = upd_go && ins_ok;
        cell_ctrl.del   = upd_go && del_ok;
        cell_ctrl.value = r_op.value;
        cell_ctrl.index = r_op.index;
        cell_ctrl.count = r_count;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_width     <= W_BYTES_2;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (upd_go) begin
                r_count     <= n_count;
                r_width     <= n_width;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op <= i_in_word;
        end
        if (upd_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ===== rtl/sis_cell.sv =====
`default_nettype none

module sis_cell
    import sis_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire logic [INDEX_W-1:0] i_pos,
    input  wire t_entry             i_left_entry,
    input  wire logic               i_left_lt,
    input  wire t_entry             i_right_entry,
    output t_entry                  o_entry,
    output logic                    o_lt,
    output logic                    o_eq,
    output logic                    o_sel
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_lt;
    logic   r_eq;
    logic   r_sel;
    logic   in_range;

    // A cell holds a live entry when its position is below the count.
    assign in_range = ({1'b0, i_pos} < i_ctrl.count);

    // Compare flags are taken once per operation and held for the update.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_lt  <= in_range && (r_entry < i_ctrl.value);
            r_eq  <= in_range && (r_entry == i_ctrl.value);
            r_sel <= (i_pos == i_ctrl.index);
        end
    end

    // Cells at or above the insertion point shift up; on removal they pull
    // the neighbour above down over the gap.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (!r_lt) begin
                n_entry = i_left_lt ? i_ctrl.value : i_left_entry;
            end
        end else if (i_ctrl.del) begin
            if (!r_lt) begin
                n_entry = i_right_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_sel   = r_sel;

endmodule

`default_nettype wire

// ===== rtl/sis_group.sv =====
`default_nettype none

module sis_group
    import sis_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [GROUP_SIZE-1:0] i_eq,
    input  wire logic [GROUP_SIZE-1:0] i_sel,
    input  wire t_entry                i_entry [GROUP_SIZE],
    output logic                       o_hit,
    output t_entry                     o_rd
);

    logic   r_hit;
    t_entry r_rd;
    t_entry n_rd;

    // Selected entry of this group, zero when none is selected.
    always_comb begin
        n_rd = '0;
        for (int j = 0; j < GROUP_SIZE; j++) begin
            n_rd = n_rd | (i_sel[j] ? i_entry[j] : t_entry'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= |i_eq;
        r_rd  <= n_rd;
    end

    assign o_hit = r_hit;
    assign o_rd  = r_rd;

endmodule

`default_nettype wire

// ===== rtl/sis_checker.sv =====
`default_nettype none

module sis_checker
    import sis_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_word  i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    logic [LEN_W-1:0] exp_len;

    // Packed length from the reported count and width.
    assign exp_len = LEN_W'({3'b0, o_out_word.count} * {8'b0, o_out_word.width_bytes});

    // A stalled result word stays.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed under stall");

    // One operation at a time: the input stalls after an accepted word.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted during an operation");

    // The byte length agrees with count and width.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.byte_length == exp_len)
        else $error("byte length mismatch");

    // Width is one of the legal element sizes.
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.width_bytes == W_BYTES_2) ||
                        (o_out_word.width_bytes == W_BYTES_4) ||
                        (o_out_word.width_bytes == W_BYTES_8))
        else $error("illegal element width");

    // A failed operation returns no data.
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_OK) |-> o_out_word.read_value == '0)
        else $error("read value on a failed operation");

endmodule

bind sorted_integer_set sis_checker u_sis_checker (.*);

`default_nettype wire

// ===== dv/sorted_integer_set_check.sv =====
`timescale 1ns / 100ps

// Watches both channels of the sorted set, predicts the result word for every
// accepted operation and compares each delivered result word with the oldest
// prediction, field by field.
module sorted_integer_set_check
    import sis_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_word i_out_word,
    output int             o_pending,
    output int             o_fail_count
);

    // Predicted contents of the set, kept in ascending order.
    t_entry             set_vals [CAPACITY];
    int unsigned        set_size;
    logic [WIDTH_W-1:0] elem_width;
    t_out_word          pending_results [$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        set_size     = 0;
        elem_width   = W_BYTES_2;
    end

    // Prints one line per failure (up to a limit) and counts every one.
    task automatic report_failure(input string msg);
        if (o_fail_count < 200) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    // Smallest element width that holds the value without loss.
    function automatic logic [WIDTH_W-1:0] bytes_for(input t_entry v);
        logic signed [31:0] low32;
        logic signed [15:0] low16;
        low32 = v[31:0];
        low16 = v[15:0];
        if (v != t_entry'(low32)) return W_BYTES_8;
        if (v != t_entry'(low16)) return W_BYTES_4;
        return W_BYTES_2;
    endfunction

    // Applies one operation to the predicted set and works out its result word.
    task automatic predict_set_op(input t_in_word w, output t_out_word r);
        int unsigned        pos;
        logic               hit;
        logic [WIDTH_W-1:0] need;
        r        = '0;
        r.status = ST_OK;

        // First place whose entry is not below the value.
        pos = 0;
        while (pos < set_size && set_vals[pos] < w.value) pos++;
        hit = (pos < set_size) && (set_vals[pos] == w.value);

        case (w.kind)
            K_ADD: begin
                if (set_size >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (hit) begin
                    r.status = ST_MISS;
                end else begin
                    for (int unsigned i = set_size; i > pos; i--) set_vals[i] = set_vals[i - 1];
                    set_vals[pos] = w.value;
                    set_size++;
                    need = bytes_for(w.value);
                    if (need > elem_width) elem_width = need;
                end
            end
            K_REMOVE: begin
                if (!hit) begin
                    r.status = ST_MISS;
                end else begin
                    for (int unsigned i = pos; i + 1 < set_size; i++) set_vals[i] = set_vals[i + 1];
                    set_size--;
                end
            end
            K_FIND: begin
                if (!hit) r.status = ST_MISS;
            end
            default: begin
                if (w.index >= set_size) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = set_vals[w.index];
                end
            end
        endcase

        r.count       = COUNT_W'(set_size);
        r.width_bytes = elem_width;
        r.byte_length = LEN_W'(set_size * elem_width);
    endtask

    // Result words are checked before the operation word of the same edge is
    // predicted, since a result can never come from a word accepted that edge.
    always @(posedge i_clk) begin : watch_channels
        t_out_word want;
        t_out_word got;
        int        delta;
        if (!i_rst_n) begin
            set_size   = 0;
            elem_width = W_BYTES_2;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            delta = 0;
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (pending_results.size() == 0) begin
                    report_failure($sformatf("result word with no prediction waiting: %h", got));
                end else begin
                    want = pending_results.pop_front();
                    delta--;
                    if (got.status !== want.status)
                        report_failure($sformatf("status: got %0d, expected %0d",
                                                 got.status, want.status));
                    if (got.read_value !== want.read_value)
                        report_failure($sformatf("read_value: got %h, expected %h",
                                                 got.read_value, want.read_value));
                    if (got.count !== want.count)
                        report_failure($sformatf("count: got %0d, expected %0d",
                                                 got.count, want.count));
                    if (got.width_bytes !== want.width_bytes)
                        report_failure($sformatf("width_bytes: got %0d, expected %0d",
                                                 got.width_bytes, want.width_bytes));
                    if (got.byte_length !== want.byte_length)
                        report_failure($sformatf("byte_length: got %0d, expected %0d",
                                                 got.byte_length, want.byte_length));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_set_op(i_in_word, want);
                pending_results.push_back(want);
                delta++;
            end
            o_pending <= o_pending + delta;
        end
    end

endmodule

// ===== dv/sorted_integer_set_test.sv =====
`timescale 1ns / 100ps

module sorted_integer_set_test;
    import sis_pkg::*;

    localparam int POOL_SIZE      = 320;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 12;
    localparam int NUM_EDGES      = 12;

    // Values at the borders of the element widths and of the 64-bit range.
    localparam t_entry EDGE_VALS [NUM_EDGES] = '{
        64'sd32767, -64'sd32768, 64'sd32768, -64'sd32769,
        64'sd2147483647, -64'sd2147483648, 64'sd2147483648, -64'sd2147483649,
        64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000, 64'sd0, -64'sd1
    };

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      in_valid    = 1'b0;
    t_in_word  in_word     = '0;
    logic      out_stall   = 1'b0;
    logic      quiet       = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    int        pending;
    int        fail_count;
    int        idle_cycles = 0;
    int        stall_run   = 0;
    int        pool_cursor = 0;
    t_entry    value_pool [POOL_SIZE];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sorted_integer_set dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    sorted_integer_set_check checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Result side stalls in runs: mostly short, now and then a long one.
    always @(posedge clk) begin : drive_out_stall
        int pick;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (quiet || pick < 60) begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 3);
            end else if (pick < 95) begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(10, 40);
            end
        end
    end

    // Ends the run if no word moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_integer_set verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_word make_word(input t_kind op_kind, input t_entry op_value,
                                           input logic [INDEX_W-1:0] op_index);
        t_in_word w;
        w.kind  = op_kind;
        w.value = op_value;
        w.index = op_index;
        return w;
    endfunction

    // Values spread over every width class, plus the border values.
    function automatic t_entry random_value();
        logic signed [15:0] low16;
        logic signed [31:0] low32;
        case ($urandom_range(0, 9))
            0:       return t_entry'($urandom_range(0, 8)) - 4;
            1, 2, 3: begin
                low16 = 16'($urandom);
                return t_entry'(low16);
            end
            4, 5:    begin
                low32 = $urandom;
                return t_entry'(low32);
            end
            6, 7:    return {$urandom, $urandom};
            default: return EDGE_VALS[$urandom_range(0, NUM_EDGES - 1)];
        endcase
    endfunction

    // Any operation; values mostly from the pool so that lookups often hit.
    function automatic t_in_word random_word(input t_kind op_kind);
        t_entry             v;
        logic [INDEX_W-1:0] idx;
        if ($urandom_range(0, 3) != 0) v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else v = random_value();
        if ($urandom_range(0, 1) != 0) idx = INDEX_W'($urandom);
        else idx = INDEX_W'($urandom_range(0, 31));
        return make_word(op_kind, v, idx);
    endfunction

    // Waits a random gap, then offers the word until it is accepted.
    task automatic send_word(input t_in_word w);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    // A run of words biased towards one operation walking through the pool.
    task automatic run_round(input t_kind main_kind, input int n_words, input int main_pct);
        t_in_word w;
        for (int n = 0; n < n_words; n++) begin
            if (n % 100 == 0) quiet <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < main_pct) begin
                w = make_word(main_kind, value_pool[pool_cursor], INDEX_W'($urandom));
                pool_cursor = (pool_cursor + 1) % POOL_SIZE;
            end else begin
                w = random_word(t_kind'($urandom_range(0, 3)));
            end
            send_word(w);
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = random_value();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty set: reads out of range, lookups miss.
        send_word(make_word(K_GET, 64'sd0, 8'd0));
        send_word(make_word(K_GET, 64'sd0, 8'd255));
        send_word(make_word(K_FIND, 64'sd5, 8'd0));
        send_word(make_word(K_REMOVE, 64'sd5, 8'd0));
        // Duplicate add, then growth from two to four and to eight bytes.
        send_word(make_word(K_ADD, 64'sd0, 8'd0));
        send_word(make_word(K_ADD, 64'sd0, 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[0], 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[1], 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[2], 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[3], 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[4], 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[5], 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[6], 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[9], 8'd0));
        send_word(make_word(K_ADD, EDGE_VALS[8], 8'd0));
        // Lookups and reads at both ends of the set.
        send_word(make_word(K_FIND, EDGE_VALS[9], 8'd0));
        send_word(make_word(K_FIND, 64'sd1, 8'd0));
        send_word(make_word(K_GET, 64'sd0, 8'd0));
        send_word(make_word(K_GET, 64'sd0, 8'd9));
        send_word(make_word(K_GET, 64'sd0, 8'd10));
        // Removals at the ends and in the middle; the width stays at eight.
        send_word(make_word(K_REMOVE, EDGE_VALS[9], 8'd0));
        send_word(make_word(K_REMOVE, EDGE_VALS[9], 8'd0));
        send_word(make_word(K_REMOVE, EDGE_VALS[8], 8'd0));
        send_word(make_word(K_REMOVE, 64'sd0, 8'd0));
        send_word(make_word(K_GET, 64'sd0, 8'd0));

        // Fill past capacity, mix, drain, mix again.
        run_round(K_ADD, 400, 85);
        run_round(K_FIND, 400, 0);
        run_round(K_REMOVE, 400, 85);
        run_round(K_FIND, 200, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("sorted_integer_set verification clean");
        end else begin
            $display("sorted_integer_set verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sis_pkg.sv
rtl/sis_cell.sv
rtl/sis_group.sv
rtl/sorted_integer_set.sv
rtl/sis_checker.sv
dv/sorted_integer_set_check.sv
dv/sorted_integer_set_test.sv
